[src/reservoir_sampler_core_defines.svh]
// Assertion macros shared by the reservoir sampler RTL.
// Each check is sampled on clk_i and held off while rst_ni is low.
`ifndef RESERVOIR_SAMPLER_CORE_DEFINES_SVH
`define RESERVOIR_SAMPLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define RS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("reservoir sampler check failed");
`define RS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("reservoir sampler forbidden condition");
`else
`define RS_ASSERT(lbl, prop)
`define RS_ASSERT_NEVER(lbl, cond)
`endif

`endif

[src/rs_pkg.sv]
`default_nettype none

package rs_pkg;

  // Reservoir geometry
  localparam int SLOTS  = 128;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int K_W    = ($clog2(SLOTS + 1) > 8) ? $clog2(SLOTS + 1) : 8;

  // Field widths
  localparam int WORD_W = 64;
  localparam int RND_W  = 31;
  localparam int IDX_W  = 7;
  localparam int CNT_W  = 32;
  localparam int SIZE_W = 8;
  localparam int STEP_W = $clog2(RND_W);

  // Input tdata layout, lowest bit first
  localparam int IN_ITEM_LO = 0;
  localparam int IN_RND_LO  = IN_ITEM_LO + WORD_W;
  localparam int IN_IDX_LO  = IN_RND_LO + RND_W;
  localparam int IN_BITS    = IN_IDX_LO + IDX_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int OUT_TAKEN_LO = 0;
  localparam int OUT_SLOT_LO  = OUT_TAKEN_LO + 1;
  localparam int OUT_DATA_LO  = OUT_SLOT_LO + IDX_W;
  localparam int OUT_VALID_LO = OUT_DATA_LO + WORD_W;
  localparam int OUT_SEEN_LO  = OUT_VALID_LO + 1;
  localparam int OUT_BITS     = OUT_SEEN_LO + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Configuration
  localparam int             PADDR_W    = 3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(100);

  typedef enum logic [1:0] {
    FUNC_OFFER = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } rs_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } rs_state_e;

  // Request from the sequencer to the slot store
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              clr;
  } rs_mem_req_t;

endpackage

`default_nettype wire

[src/rs_divider.sv]
`default_nettype none
`include "reservoir_sampler_core_defines.svh"

// Bit-serial restoring remainder unit: one dividend bit per cycle.
module rs_divider
  import rs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RND_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [CNT_W-1:0]      rem_o
);

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [RND_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[RND_W-1]};
    diff  = trial - {1'b0, dvs_q};
    rem_d = (trial >= {1'b0, dvs_q}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  // Control: step counter, busy and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && !start_i && (step_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(RND_W - 1);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  `RS_ASSERT(a_rem_below_divisor, done_q |-> (rem_q < dvs_q))
  `RS_ASSERT_NEVER(a_start_while_busy, start_i && busy_q)

endmodule

`default_nettype wire

[src/rs_store.sv]
`default_nettype none

// Slot memory with one valid flag per slot.
module rs_store
  import rs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rs_mem_req_t       req_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  output logic [WORD_W-1:0]      rdata_o,
  output logic                   rvalid_o
);

  logic [WORD_W-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0]  valid_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvalid_q;

  // Write and registered read of the record array
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // Valid flags: drop all on clear, set on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

`default_nettype wire

[src/reservoir_sampler_core.sv]
// Reservoir sampler, Algorithm R, over 64-bit records.
// Offer in fill phase, read, clear, no-op: ST_IDLE takes the transfer, ST_FIN loads the result
// register once the output is free. Offer past the fill phase: ST_DIV waits between them for the
// 31-step bit-serial remainder unit (one quotient bit per cycle). Input is taken only in ST_IDLE.
// Reset (rst_ni low, async): count zero, all slots invalid, sample_size 100.
`default_nettype none
`include "reservoir_sampler_core_defines.svh"

module reservoir_sampler_core
  import rs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // APB configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: item_word[63:0], random_value[94:64], read_index[101:95], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: func[1:0]
  input  wire logic [1:0]             s_axis_tuser,
  // Result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata: taken[0], slot[7:1], slot_data[71:8], slot_valid[72],
  //        items_seen[104:73], zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  rs_state_e         state_q, state_d;
  rs_func_e          func_q, func_in;
  logic [WORD_W-1:0] item_q;
  logic [IDX_W-1:0]  ridx_q;
  logic              ridx_ok_q;
  logic [CNT_W-1:0]  seen_q;
  logic [CNT_W-1:0]  j_q;
  logic [SIZE_W-1:0] size_q;
  logic              m_tvalid_q;
  logic [OUT_TDATA_W-1:0] m_tdata_q;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              div_start;
  logic              div_done;
  logic [CNT_W-1:0]  div_rem;
  logic [CNT_W-1:0]  n_inc;
  logic [K_W-1:0]    k_eff;
  logic              fill;
  logic              take;
  logic              cfg_we;
  rs_mem_req_t       mem_req;
  logic [WORD_W-1:0] rd_data;
  logic              rd_valid;
  logic [IDX_W-1:0]  in_ridx;
  logic [IDX_W-1:0]  o_slot;
  logic [WORD_W-1:0] o_data;
  logic              o_taken;
  logic              o_valid;
  logic [OUT_TDATA_W-1:0] o_tdata;

  // Configuration register
  assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  // Effective sample size and saturating count step
  always_comb begin
    k_eff = (K_W'(size_q) > K_W'(SLOTS)) ? K_W'(SLOTS) : K_W'(size_q);
    n_inc = (seen_q == '1) ? seen_q : seen_q + CNT_W'(1);
    fill  = (n_inc <= CNT_W'(k_eff));
    take  = (j_q < CNT_W'(k_eff));
  end

  assign func_in  = rs_func_e'(s_axis_tuser);
  assign in_ridx  = s_axis_tdata[IN_IDX_LO +: IDX_W];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_tvalid_q || m_axis_tready;

  // Sequencer: next state, unit start, store requests
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    mem_req       = '0;
    mem_req.waddr = j_q[SLOT_W-1:0];
    mem_req.raddr = SLOT_W'(in_ridx);
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_FIN;
          unique case (func_in)
            FUNC_OFFER: begin
              if (!fill) begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            FUNC_READ:  mem_req.re  = 1'b1;
            FUNC_CLEAR: mem_req.clr = 1'b1;
            FUNC_NOP:   ;
            default:    ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load_out   = 1'b1;
          mem_req.we = (func_q == FUNC_OFFER) && take;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept && func_in == FUNC_OFFER) begin
        seen_q <= n_inc;
      end else if (accept && func_in == FUNC_CLEAR) begin
        seen_q <= '0;
      end
    end
  end

  // Hold the operation payload and the chosen slot
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= func_in;
      item_q    <= s_axis_tdata[IN_ITEM_LO +: WORD_W];
      ridx_q    <= in_ridx;
      ridx_ok_q <= (32'(in_ridx) < SLOTS);
      j_q       <= n_inc - CNT_W'(1);
    end else if (div_done) begin
      j_q <= div_rem;
    end
  end

  rs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_axis_tdata[IN_RND_LO +: RND_W]),
    .divisor_i  (n_inc),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  rs_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .wdata_i  (item_q),
    .rdata_o  (rd_data),
    .rvalid_o (rd_valid)
  );

  // Form the result fields
  always_comb begin
    o_taken = 1'b0;
    o_slot  = '0;
    o_data  = '0;
    o_valid = 1'b0;
    unique case (func_q)
      FUNC_OFFER: begin
        o_taken = take;
        o_slot  = take ? j_q[IDX_W-1:0] : '0;
      end
      FUNC_READ: begin
        o_slot  = ridx_q;
        o_valid = ridx_ok_q && rd_valid;
        o_data  = o_valid ? rd_data : '0;
      end
      FUNC_CLEAR: ;
      FUNC_NOP:   ;
      default:    ;
    endcase
    o_tdata                          = '0;
    o_tdata[OUT_TAKEN_LO]            = o_taken;
    o_tdata[OUT_SLOT_LO +: IDX_W]    = o_slot;
    o_tdata[OUT_DATA_LO +: WORD_W]   = o_data;
    o_tdata[OUT_VALID_LO]            = o_valid;
    o_tdata[OUT_SEEN_LO +: CNT_W]    = seen_q;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (load_out) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_tdata_q <= o_tdata;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  `RS_ASSERT(a_div_done_in_div, div_done |-> (state_q == ST_DIV))
  `RS_ASSERT(a_write_on_release, mem_req.we |-> (state_q == ST_FIN && out_free))
  `RS_ASSERT(a_clear_zeroes_count, (accept && func_in == FUNC_CLEAR) |=> (seen_q == '0))
  `RS_ASSERT_NEVER(a_no_overwrite, load_out && m_tvalid_q && !m_axis_tready)

endmodule

`default_nettype wire
